>>> rtl/assert_macros.svh
// Assertion macros shared by the motion segment executor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define MSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define MSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/mse_pkg.sv
// Shared types and constants of the motion segment executor
`default_nettype none
package mse_pkg;
    localparam int POS_W = 23;
    localparam int ID_W = 32;
    localparam int STEP_W = 16;
    localparam int CMD_W = 3;
    localparam int CODE_W = 3;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [CMD_W-1:0] CMD_SEGMENT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ESTOP_ON = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ESTOP_OFF = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ABORT = 3'd6;

    localparam logic [CODE_W-1:0] ST_QUEUED = 3'd0;
    localparam logic [CODE_W-1:0] ST_EXECUTING = 3'd1;
    localparam logic [CODE_W-1:0] ST_COMPLETE = 3'd2;
    localparam logic [CODE_W-1:0] ST_RESET = 3'd3;
    localparam logic [CODE_W-1:0] ST_FAULT = 3'd4;

    localparam logic [1:0] CFG_MIN_POS = 2'd0;
    localparam logic [1:0] CFG_MAX_POS = 2'd1;
    localparam logic [1:0] CFG_MAX_STEP = 2'd2;
    localparam logic [1:0] CFG_FALLBACK = 2'd3;

    localparam logic [1:0] EX_IDLE = 2'd0;
    localparam logic [1:0] EX_RUNNING = 2'd1;
    localparam logic [1:0] EX_ABORTING = 2'd2;
    localparam logic [1:0] EX_FAULT = 2'd3;

    localparam logic [1:0] MM_NORMAL = 2'd0;
    localparam logic [1:0] MM_ESTOP = 2'd1;
    localparam logic [1:0] MM_LATCHED = 2'd2;

    typedef logic signed [POS_W-1:0] t_pos;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;      // capture input beat
        logic enqueue;      // write captured segment into the queue
        logic fetch;        // read queue head
        logic start;        // take fetched entry as active segment
        logic move;         // step all axes
        logic measure;      // take measurement
        logic clear_q;      // empty the queue
        logic do_reset;     // soft reset of segment state
        logic emit;         // load output register
        logic emit_pos;     // output is a position command
        logic [CODE_W-1:0] code;
        logic [1:0] id_sel; // 0 none, 1 input id, 2 active id
        logic emit_last;
    } t_ctl;

    localparam logic [1:0] ID_NONE = 2'd0;
    localparam logic [1:0] ID_INPUT = 2'd1;
    localparam logic [1:0] ID_ACTIVE = 2'd2;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic q_full;
        logic q_empty;
        logic limit_bad;
        logic reached;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/mse_datapath.sv
// Datapath: queue memory, axis positions, limit check and result register
`default_nettype none
`include "assert_macros.svh"
module mse_datapath #(
    parameter int QUEUE_DEPTH = mse_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mse_pkg::t_ctl              i_ctl,
    output mse_pkg::t_sts                   o_sts,
    input  wire logic [mse_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [mse_pkg::ID_W-1:0]   i_seg_id,
    input  wire logic signed [mse_pkg::POS_W-1:0] i_pos_a,
    input  wire logic signed [mse_pkg::POS_W-1:0] i_pos_b,
    input  wire logic signed [mse_pkg::POS_W-1:0] i_pos_c,
    input  wire logic [mse_pkg::STEP_W-1:0] i_seg_step,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [31:0]                i_cfg_data,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [mse_pkg::CODE_W-1:0]      o_status_code,
    output logic [mse_pkg::ID_W-1:0]        o_report_id,
    output logic signed [mse_pkg::POS_W-1:0] o_cmd_a,
    output logic signed [mse_pkg::POS_W-1:0] o_cmd_b,
    output logic signed [mse_pkg::POS_W-1:0] o_cmd_c,
    output logic                            o_last
);
    import mse_pkg::*;
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_W + 3 * POS_W + STEP_W;

    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_slot;

    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_id;
    t_pos             r_in [3];
    logic [STEP_W-1:0] r_step_in;

    t_pos r_min, r_max;
    logic [STEP_W-1:0] r_max_step, r_fallback;

    t_pos r_meas [3];
    t_pos r_cur [3];
    t_pos r_tgt [3];
    t_pos r_prev [3];
    logic r_first, r_ever;
    logic [ID_W-1:0] r_act_id;
    logic [STEP_W-1:0] r_act_step;

    t_pos f_tgt [3];
    logic [STEP_W-1:0] f_step, f_clamp;
    t_pos n_cur [3];
    logic [2:0] ax_reach;
    logic [2:0] ax_bad;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [AW+CW:0] s;
        s = {{(CW+1){1'b0}}, a} + {{(AW+1){1'b0}}, b};
        if (s >= (AW+CW+1)'(QUEUE_DEPTH)) s = s - (AW+CW+1)'(QUEUE_DEPTH);
        return s[AW-1:0];
    endfunction

    assign n_slot = wrap_add(r_head, r_count);
    assign f_tgt[0] = r_rd[3*POS_W+STEP_W-1 -: POS_W];
    assign f_tgt[1] = r_rd[2*POS_W+STEP_W-1 -: POS_W];
    assign f_tgt[2] = r_rd[POS_W+STEP_W-1 -: POS_W];
    assign f_step = r_rd[STEP_W-1:0];
    always_comb begin
        f_clamp = (f_step > r_max_step) ? r_max_step : f_step;
        if (f_clamp == '0) f_clamp = r_fallback;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [POS_W+1:0] err, mag;
            err = {{2{r_tgt[i][POS_W-1]}}, r_tgt[i]} - {{2{r_cur[i][POS_W-1]}}, r_cur[i]};
            mag = err[POS_W+1] ? -err : err;
            if (mag > $signed({{(POS_W+2-STEP_W){1'b0}}, r_act_step})) begin
                ax_reach[i] = 1'b0;
                n_cur[i] = err[POS_W+1] ? r_cur[i] - t_pos'({{(POS_W-STEP_W){1'b0}}, r_act_step})
                                        : r_cur[i] + t_pos'({{(POS_W-STEP_W){1'b0}}, r_act_step});
            end else begin
                ax_reach[i] = 1'b1;
                n_cur[i] = r_tgt[i];
            end
            ax_bad[i] = (r_tgt[i] < r_min) || (r_tgt[i] > r_max);
        end
    end

    assign o_sts.cmd = r_cmd;
    assign o_sts.q_full = (r_count >= CW'(QUEUE_DEPTH));
    assign o_sts.q_empty = (r_count == '0);
    assign o_sts.limit_bad = |ax_bad;
    assign o_sts.reached = &ax_reach;
    assign o_sts.out_busy = o_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_ctl.enqueue) r_mem[n_slot] <= {r_id, r_in[0], r_in[1], r_in[2], r_step_in};
        r_rd <= r_mem[r_head];
        if (i_ctl.load_in) begin
            r_id <= i_seg_id;
            r_in[0] <= i_pos_a;
            r_in[1] <= i_pos_b;
            r_in[2] <= i_pos_c;
            r_step_in <= i_seg_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
            r_head <= '0;
            r_count <= '0;
            r_min <= '0;
            r_max <= 23'sd2000000;
            r_max_step <= 16'd1000;
            r_fallback <= 16'd200;
            r_first <= 1'b1;
            r_ever <= 1'b0;
            r_act_id <= '0;
            r_act_step <= '0;
            for (int i = 0; i < 3; i++) begin
                r_meas[i] <= '0;
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
                r_prev[i] <= '0;
            end
            o_out_valid <= 1'b0;
            o_kind <= 1'b0;
            o_status_code <= '0;
            o_report_id <= '0;
            o_cmd_a <= '0;
            o_cmd_b <= '0;
            o_cmd_c <= '0;
            o_last <= 1'b0;
        end else begin
            if (i_ctl.load_in) r_cmd <= i_cmd;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MIN_POS:  r_min <= i_cfg_data[POS_W-1:0];
                    CFG_MAX_POS:  r_max <= i_cfg_data[POS_W-1:0];
                    CFG_MAX_STEP: r_max_step <= i_cfg_data[STEP_W-1:0];
                    CFG_FALLBACK: r_fallback <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.clear_q) r_count <= '0;
            else if (i_ctl.enqueue) r_count <= r_count + 1'b1;
            else if (i_ctl.start) begin
                r_count <= r_count - 1'b1;
                r_head <= wrap_add(r_head, CW'(1));
            end
            if (i_ctl.start) begin
                r_act_id <= r_rd[EW-1 -: ID_W];
                r_act_step <= f_clamp;
                r_ever <= 1'b1;
                r_first <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_tgt[i] <= f_tgt[i];
                    r_cur[i] <= r_first ? r_meas[i] : r_prev[i];
                end
            end
            if (i_ctl.move)
                for (int i = 0; i < 3; i++) r_cur[i] <= n_cur[i];
            if (i_ctl.measure) begin
                for (int i = 0; i < 3; i++) begin
                    r_meas[i] <= r_in[i];
                    if (r_ever) r_cur[i] <= r_in[i];
                end
            end
            // commit previous target once limits pass (controller asks with emit of executing)
            if (i_ctl.emit && i_ctl.code == ST_EXECUTING && !i_ctl.emit_pos)
                for (int i = 0; i < 3; i++) r_prev[i] <= r_tgt[i];
            if (i_ctl.do_reset) begin
                r_first <= 1'b1;
                r_act_id <= '0;
            end
            if (i_ctl.emit) begin
                o_out_valid <= 1'b1;
                o_kind <= i_ctl.emit_pos;
                o_status_code <= i_ctl.emit_pos ? ST_QUEUED : i_ctl.code;
                o_report_id <= (i_ctl.id_sel == ID_INPUT) ? r_id :
                               (i_ctl.id_sel == ID_ACTIVE) ? r_act_id : '0;
                o_cmd_a <= i_ctl.emit_pos ? r_cur[0] : '0;
                o_cmd_b <= i_ctl.emit_pos ? r_cur[1] : '0;
                o_cmd_c <= i_ctl.emit_pos ? r_cur[2] : '0;
                o_last <= i_ctl.emit_last;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    `MSE_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_ctl.emit, !(o_out_valid && i_out_stall), "result register overwritten while stalled")
    `MSE_ASSERT_IMP(a_enq_room, i_clk, i_rst_n, i_ctl.enqueue, r_count < CW'(QUEUE_DEPTH), "enqueue into full queue")
    `MSE_ASSERT_IMP(a_start_nonempty, i_clk, i_rst_n, i_ctl.start, r_count != '0, "start from empty queue")
endmodule
`default_nettype wire

>>> rtl/mse_ctrl.sv
// Controller: sequences one input beat into up to three result beats
`default_nettype none
`include "assert_macros.svh"
module mse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire mse_pkg::t_sts i_sts,
    output mse_pkg::t_ctl      o_ctl
);
    import mse_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_exec, n_exec;
    logic [1:0] r_mach, n_mach;
    logic r_joint, n_joint;
    logic r_reached, n_reached;
    logic r_moved, n_moved;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_ctl = '0;
        n_state = r_state;
        n_exec = r_exec;
        n_mach = r_mach;
        n_joint = r_joint;
        n_reached = r_reached;
        n_moved = r_moved;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state = S_DECODE;
                    n_moved = 1'b0;
                end
            end
            S_DECODE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                    unique case (i_sts.cmd)
                        CMD_SEGMENT: begin
                            o_ctl.emit = 1'b1;
                            o_ctl.id_sel = ID_INPUT;
                            if (r_mach != MM_NORMAL || r_exec == EX_ABORTING || !r_joint
                                || i_sts.q_full) begin
                                o_ctl.code = ST_FAULT;
                                o_ctl.emit_last = 1'b1;
                            end else begin
                                o_ctl.code = ST_QUEUED;
                                o_ctl.enqueue = 1'b1;
                                o_ctl.emit_last = (r_exec != EX_IDLE);
                                if (r_exec == EX_IDLE) n_state = S_FETCH;
                            end
                        end
                        CMD_MEASURE: begin
                            o_ctl.measure = 1'b1;
                            n_joint = 1'b1;
                        end
                        CMD_TICK: begin
                            if (r_exec == EX_RUNNING) begin
                                if (!r_moved) begin
                                    o_ctl.move = 1'b1;
                                    n_moved = 1'b1;
                                    n_reached = i_sts.reached;
                                    n_state = S_DECODE;
                                end else begin
                                    o_ctl.emit = 1'b1;
                                    o_ctl.emit_pos = 1'b1;
                                    o_ctl.emit_last = !r_reached;
                                    if (r_reached) n_state = S_DONE;
                                end
                            end
                        end
                        CMD_RESET: begin
                            if (r_mach != MM_ESTOP) begin
                                n_mach = MM_NORMAL;
                                n_exec = EX_IDLE;
                                o_ctl.clear_q = 1'b1;
                                o_ctl.do_reset = 1'b1;
                                o_ctl.emit = 1'b1;
                                o_ctl.code = ST_RESET;
                                o_ctl.emit_last = 1'b1;
                            end
                        end
                        CMD_ESTOP_ON: begin
                            if (r_mach != MM_ESTOP) begin
                                n_mach = MM_ESTOP;
                                n_exec = EX_FAULT;
                                o_ctl.clear_q = 1'b1;
                                o_ctl.emit = 1'b1;
                                o_ctl.code = ST_FAULT;
                                o_ctl.id_sel = ID_ACTIVE;
                                o_ctl.emit_last = 1'b1;
                            end
                        end
                        CMD_ESTOP_OFF: begin
                            if (r_mach == MM_ESTOP) n_mach = MM_NORMAL;
                        end
                        CMD_ABORT: begin
                            n_exec = EX_ABORTING;
                            o_ctl.clear_q = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.code = ST_COMPLETE;
                    o_ctl.id_sel = ID_ACTIVE;
                    o_ctl.emit_last = i_sts.q_empty;
                    if (i_sts.q_empty) begin
                        n_exec = EX_IDLE;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_READ;
            S_READ: n_state = S_START;
            S_START: begin
                o_ctl.start = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.id_sel = ID_ACTIVE;
                    o_ctl.emit_last = 1'b1;
                    n_state = S_IDLE;
                    if (i_sts.limit_bad) begin
                        o_ctl.code = ST_FAULT;
                        n_mach = MM_LATCHED;
                        n_exec = EX_FAULT;
                    end else begin
                        o_ctl.code = ST_EXECUTING;
                        n_exec = EX_RUNNING;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_exec <= EX_IDLE;
            r_mach <= MM_NORMAL;
            r_joint <= 1'b0;
            r_reached <= 1'b0;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exec <= n_exec;
            r_mach <= n_mach;
            r_joint <= n_joint;
            r_reached <= n_reached;
            r_moved <= n_moved;
        end
    end

    `MSE_ASSERT_IMP(a_run_normal, i_clk, i_rst_n, r_exec == EX_RUNNING, r_mach == MM_NORMAL, "running outside normal mode")
    `MSE_ASSERT_NXT(a_start_check, i_clk, i_rst_n, o_ctl.start, r_state == S_CHECK, "start not followed by limit check")
    `MSE_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall, "input open while busy")
endmodule
`default_nettype wire

>>> rtl/motion_segment_executor.sv
// Top level of the motion segment executor
// Input channel: i_in_valid / o_in_stall with cmd, seg_id, pos_a..c, seg_step.
// Output channel: o_out_valid / i_out_stall with one result beat per handshake;
// o_last marks the final beat caused by an input beat.
// Configuration: i_cfg_valid / o_cfg_ready, index 0 min, 1 max, 2 max step,
// 3 fallback step; write only while idle.
// The first result is registered from the decode state; a tick first steps the
// axes and then presents the position. Completion adds the complete beat, and a
// segment start passes the fetch, read, start and check states for the queue
// read and limit check before its beat.
// The input is stalled until all work of the item is done; results wait in a
// single output register, and the controller holds while the receiver stalls.
// Reset (synchronous, active low) empties the queue, restores register
// defaults and clears all modes; no result is pending after reset.
`default_nettype none
module motion_segment_executor #(
    parameter int QUEUE_DEPTH = mse_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [mse_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [mse_pkg::ID_W-1:0]   i_seg_id,
    input  wire logic signed [mse_pkg::POS_W-1:0] i_pos_a,
    input  wire logic signed [mse_pkg::POS_W-1:0] i_pos_b,
    input  wire logic signed [mse_pkg::POS_W-1:0] i_pos_c,
    input  wire logic [mse_pkg::STEP_W-1:0] i_seg_step,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [31:0]                i_cfg_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_kind,
    output logic [mse_pkg::CODE_W-1:0]      o_status_code,
    output logic [mse_pkg::ID_W-1:0]        o_report_id,
    output logic signed [mse_pkg::POS_W-1:0] o_cmd_a,
    output logic signed [mse_pkg::POS_W-1:0] o_cmd_b,
    output logic signed [mse_pkg::POS_W-1:0] o_cmd_c,
    output logic                            o_last
);
    import mse_pkg::*;
    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_sts(sts), .o_ctl(ctl)
    );

    mse_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_cmd(i_cmd), .i_seg_id(i_seg_id), .i_pos_a(i_pos_a), .i_pos_b(i_pos_b),
        .i_pos_c(i_pos_c), .i_seg_step(i_seg_step),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid), .o_kind(o_kind),
        .o_status_code(o_status_code), .o_report_id(o_report_id),
        .o_cmd_a(o_cmd_a), .o_cmd_b(o_cmd_b), .o_cmd_c(o_cmd_c), .o_last(o_last)
    );
endmodule
`default_nettype wire

>>> dv/mse_checker.sv
// Checker for the motion segment executor: predicts results from accepted beats and compares
`default_nettype none
module mse_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_seg_id,
    input  wire logic signed [22:0] i_pos_a,
    input  wire logic signed [22:0] i_pos_b,
    input  wire logic signed [22:0] i_pos_c,
    input  wire logic [15:0] i_seg_step,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_kind,
    input  wire logic [2:0]  i_status_code,
    input  wire logic [31:0] i_report_id,
    input  wire logic signed [22:0] i_cmd_a,
    input  wire logic signed [22:0] i_cmd_b,
    input  wire logic signed [22:0] i_cmd_c,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending,
    output int               o_results
);
    import mse_pkg::*;

    localparam int EXP_DEPTH = 256;

    typedef struct packed {
        logic        kind;
        logic [2:0]  code;
        logic [31:0] id;
        logic signed [22:0] a;
        logic signed [22:0] b;
        logic signed [22:0] c;
        logic        last;
    } t_result;

    t_result exp_buf[EXP_DEPTH];
    int exp_wr, exp_rd, exp_cnt;

    t_pos lim_lo, lim_hi;
    logic [15:0] step_cap, step_fallback;
    logic [1:0] ex_mode, mach_mode;
    logic have_meas, started_once, first_seg;
    t_pos meas[3], cur[3], tgt[3], prev_tgt[3];
    logic [31:0] act_id;
    logic [15:0] act_step;
    logic [31:0] q_id[16];
    t_pos q_tgt[16][3];
    logic [15:0] q_step[16];
    int q_count, q_head;
    int new_count;

    assign o_pending = exp_cnt;

    task automatic add_result(input t_result r);
        exp_buf[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_cnt++;
        new_count++;
    endtask

    task automatic push_status(input logic [2:0] code, input logic [31:0] id);
        t_result r;
        r = '0;
        r.code = code;
        r.id = id;
        add_result(r);
    endtask

    task automatic launch_segment();
        logic [15:0] s;
        logic bad;
        bad = 1'b0;
        if (q_count == 0) begin
            ex_mode = EX_IDLE;
            return;
        end
        act_id = q_id[q_head];
        for (int i = 0; i < 3; i++) tgt[i] = q_tgt[q_head][i];
        s = q_step[q_head];
        q_head = (q_head + 1) % 16;
        q_count--;
        started_once = 1'b1;
        if (s > step_cap) s = step_cap;
        if (s == 0) s = step_fallback;
        act_step = s;
        for (int i = 0; i < 3; i++) cur[i] = first_seg ? meas[i] : prev_tgt[i];
        first_seg = 1'b0;
        for (int i = 0; i < 3; i++)
            if (tgt[i] < lim_lo || tgt[i] > lim_hi) bad = 1'b1;
        if (bad) begin
            mach_mode = MM_LATCHED;
            ex_mode = EX_FAULT;
            push_status(ST_FAULT, act_id);
            return;
        end
        for (int i = 0; i < 3; i++) prev_tgt[i] = tgt[i];
        ex_mode = EX_RUNNING;
        push_status(ST_EXECUTING, act_id);
    endtask

    task automatic predict_beat(input logic [2:0] cmd, input logic [31:0] id,
                                input t_pos p[3], input logic [15:0] st);
        logic reached;
        longint err, mag;
        t_result r;
        new_count = 0;
        case (cmd)
            CMD_SEGMENT: begin
                if (mach_mode != MM_NORMAL || ex_mode == EX_ABORTING || !have_meas
                        || q_count >= 16) begin
                    push_status(ST_FAULT, id);
                end else begin
                    int slot;
                    slot = (q_head + q_count) % 16;
                    q_id[slot] = id;
                    for (int i = 0; i < 3; i++) q_tgt[slot][i] = p[i];
                    q_step[slot] = st;
                    q_count++;
                    push_status(ST_QUEUED, id);
                    if (ex_mode == EX_IDLE) launch_segment();
                end
            end
            CMD_MEASURE: begin
                have_meas = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    meas[i] = p[i];
                    if (started_once) cur[i] = p[i];
                end
            end
            CMD_TICK: begin
                if (ex_mode == EX_RUNNING) begin
                    reached = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        err = longint'(tgt[i]) - longint'(cur[i]);
                        mag = err < 0 ? -err : err;
                        if (mag > longint'(act_step)) begin
                            cur[i] = t_pos'(err > 0 ? longint'(cur[i]) + act_step
                                                    : longint'(cur[i]) - act_step);
                            reached = 1'b0;
                        end else begin
                            cur[i] = tgt[i];
                        end
                    end
                    r = '0;
                    r.kind = 1'b1;
                    r.a = cur[0];
                    r.b = cur[1];
                    r.c = cur[2];
                    add_result(r);
                    if (reached) begin
                        push_status(ST_COMPLETE, act_id);
                        if (q_count != 0) launch_segment();
                        else ex_mode = EX_IDLE;
                    end
                end
            end
            CMD_RESET: begin
                if (mach_mode != MM_ESTOP) begin
                    mach_mode = MM_NORMAL;
                    q_count = 0;
                    first_seg = 1'b1;
                    act_id = '0;
                    ex_mode = EX_IDLE;
                    push_status(ST_RESET, '0);
                end
            end
            CMD_ESTOP_ON: begin
                if (mach_mode != MM_ESTOP) begin
                    mach_mode = MM_ESTOP;
                    ex_mode = EX_FAULT;
                    q_count = 0;
                    push_status(ST_FAULT, act_id);
                end
            end
            CMD_ESTOP_OFF: if (mach_mode == MM_ESTOP) mach_mode = MM_NORMAL;
            CMD_ABORT: begin
                ex_mode = EX_ABORTING;
                q_count = 0;
            end
            default: ;
        endcase
        if (new_count > 0) exp_buf[(exp_wr + EXP_DEPTH - 1) % EXP_DEPTH].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at result %0d", what, got, want,
                 o_results);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        exp_wr = 0;
        exp_rd = 0;
        exp_cnt = 0;
    end

    always @(posedge i_clk) begin
        t_pos p[3];
        t_result w;
        if (!i_rst_n) begin
            lim_lo = 23'sd0;
            lim_hi = 23'sd2000000;
            step_cap = 16'd1000;
            step_fallback = 16'd200;
            ex_mode = EX_IDLE;
            mach_mode = MM_NORMAL;
            have_meas = 1'b0;
            started_once = 1'b0;
            first_seg = 1'b1;
            for (int i = 0; i < 3; i++) begin
                meas[i] = '0;
                cur[i] = '0;
                tgt[i] = '0;
                prev_tgt[i] = '0;
            end
            act_id = '0;
            act_step = '0;
            q_count = 0;
            q_head = 0;
            exp_wr = 0;
            exp_rd = 0;
            exp_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_POS:  lim_lo = t_pos'(i_cfg_data[22:0]);
                    CFG_MAX_POS:  lim_hi = t_pos'(i_cfg_data[22:0]);
                    CFG_MAX_STEP: step_cap = i_cfg_data[15:0];
                    CFG_FALLBACK: step_fallback = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (exp_cnt == 0) begin
                    report_mismatch("unexpected result", {i_kind, i_status_code}, '0);
                end else begin
                    w = exp_buf[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (i_kind !== w.kind) report_mismatch("kind", i_kind, w.kind);
                    if (i_status_code !== w.code)
                        report_mismatch("status_code", i_status_code, w.code);
                    if (i_report_id !== w.id) report_mismatch("report_id", i_report_id, w.id);
                    if (i_cmd_a !== w.a) report_mismatch("cmd_a", i_cmd_a, w.a);
                    if (i_cmd_b !== w.b) report_mismatch("cmd_b", i_cmd_b, w.b);
                    if (i_cmd_c !== w.c) report_mismatch("cmd_c", i_cmd_c, w.c);
                    if (i_last !== w.last) report_mismatch("last", i_last, w.last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                p[0] = i_pos_a;
                p[1] = i_pos_b;
                p[2] = i_pos_c;
                predict_beat(i_cmd, i_seg_id, p, i_seg_step);
            end
        end
    end
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench top for the motion segment executor: stimulus, idling, verdict
`default_nettype none
module testbench;
    import mse_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall;
    logic [2:0] i_cmd;
    logic [31:0] i_seg_id;
    logic signed [22:0] i_pos_a, i_pos_b, i_pos_c;
    logic [15:0] i_seg_step;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    logic o_out_valid, i_out_stall;
    logic o_kind;
    logic [2:0] o_status_code;
    logic [31:0] o_report_id;
    logic signed [22:0] o_cmd_a, o_cmd_b, o_cmd_c;
    logic o_last;
    int errors, pending, results;
    int send_idle_pct, recv_idle_pct;
    int hold_off;
    int cycles;
    int beats;

    motion_segment_executor uut (.*);

    mse_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_cmd, .i_seg_id,
        .i_pos_a, .i_pos_b, .i_pos_c, .i_seg_step, .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .i_out_valid(o_out_valid), .i_out_stall,
        .i_kind(o_kind), .i_status_code(o_status_code), .i_report_id(o_report_id),
        .i_cmd_a(o_cmd_a), .i_cmd_b(o_cmd_b), .i_cmd_c(o_cmd_c), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("FAIL motion_segment_executor");
                $finish;
            end
        end
    end

    // receiver stall: random per phase, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic signed [22:0] rand_pos(input int mode);
        case (mode)
            0: return 23'(int'($urandom_range(2000000)));
            1: return 23'($urandom);
            default: return 23'(int'($urandom_range(20000)) + 1000);
        endcase
    endfunction

    task automatic send_beat(input logic [2:0] cmd, input logic [31:0] id,
                             input logic signed [22:0] a, input logic signed [22:0] b,
                             input logic signed [22:0] c, input logic [15:0] st);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_seg_id <= id;
        i_pos_a <= a;
        i_pos_b <= b;
        i_pos_c <= c;
        i_seg_step <= st;
        do @(posedge i_clk); while (o_in_stall);
        beats++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic random_beat(input int mode);
        int r;
        logic [2:0] cmd;
        r = $urandom_range(99);
        if (r < 35) cmd = CMD_SEGMENT;
        else if (r < 75) cmd = CMD_TICK;
        else if (r < 83) cmd = CMD_MEASURE;
        else if (r < 88) cmd = CMD_RESET;
        else if (r < 91) cmd = CMD_ESTOP_ON;
        else if (r < 94) cmd = CMD_ESTOP_OFF;
        else if (r < 96) cmd = CMD_ABORT;
        else cmd = 3'($urandom_range(7));
        send_beat(cmd, $urandom, rand_pos(mode), rand_pos(mode), rand_pos(mode),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = '0;
        i_seg_id = '0;
        i_pos_a = '0;
        i_pos_b = '0;
        i_pos_c = '0;
        i_seg_step = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 6;
        recv_idle_pct = 57;
        hold_off = 0;
        beats = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: refusals, extremes, every command
        send_beat(CMD_SEGMENT, 32'hFFFF_FFFF, '0, '0, '0, 16'd5);
        send_beat(CMD_TICK, '0, '0, '0, '0, '0);
        send_beat(CMD_MEASURE, '0, 23'sd100, 23'sd200, 23'sd300, '0);
        send_beat(CMD_SEGMENT, 32'h1, 23'sd1100, 23'sd200, 23'sd2300, '0);
        send_beat(CMD_SEGMENT, 32'h2, 23'sd1100, 23'sd200, 23'sd2300, 16'hFFFF);
        send_beat(CMD_TICK, '0, '0, '0, '0, '0);
        send_beat(CMD_MEASURE, '0, 23'sd500, 23'sd500, 23'sd500, '0);
        repeat (12) send_beat(CMD_TICK, '0, '0, '0, '0, '0);
        send_beat(CMD_SEGMENT, 32'h3, 23'sh3FFFFF, '0, '0, 16'd1);
        send_beat(CMD_SEGMENT, 32'h4, '0, '0, '0, 16'd1);
        send_beat(CMD_ESTOP_ON, '0, '0, '0, '0, '0);
        send_beat(CMD_ESTOP_ON, '0, '0, '0, '0, '0);
        send_beat(CMD_RESET, '0, '0, '0, '0, '0);
        send_beat(CMD_ESTOP_OFF, '0, '0, '0, '0, '0);
        send_beat(CMD_UNUSED, '0, '0, '0, '0, '0);
        send_beat(CMD_RESET, '0, '0, '0, '0, '0);
        send_beat(CMD_SEGMENT, 32'h5, 23'sh400000, '0, '0, '0);
        send_beat(CMD_RESET, '0, '0, '0, '0, '0);
        send_beat(CMD_SEGMENT, 32'h6, 23'sd10, 23'sd10, 23'sd10, 16'd3);
        send_beat(CMD_ABORT, '0, '0, '0, '0, '0);
        send_beat(CMD_SEGMENT, 32'h7, 23'sd10, 23'sd10, 23'sd10, 16'd3);
        send_beat(CMD_RESET, '0, '0, '0, '0, '0);
        drain();

        // fill the queue, starting under a long receiver hold-off
        hold_off = 300;
        repeat (20) send_beat(CMD_SEGMENT, $urandom, rand_pos(0), rand_pos(0), rand_pos(0),
                              16'($urandom));
        drain();
        send_beat(CMD_RESET, '0, '0, '0, '0, '0);
        drain();

        // phase settings: defaults, wide limits with a maximal step, crossed limits, extremes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_MIN_POS, 32'(-4194304));
                    write_reg(CFG_MAX_POS, 32'd4194303);
                    write_reg(CFG_MAX_STEP, 32'd0);
                    write_reg(CFG_FALLBACK, 32'd65535);
                    send_idle_pct = 57;
                    recv_idle_pct = 6;
                end
                2: begin
                    write_reg(CFG_MIN_POS, 32'd5000);
                    write_reg(CFG_MAX_POS, 32'd1000);
                    write_reg(CFG_MAX_STEP, 32'd65535);
                    write_reg(CFG_FALLBACK, 32'd1);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                3: begin
                    write_reg(CFG_MIN_POS, 32'd0);
                    write_reg(CFG_MAX_POS, 32'd30000);
                    write_reg(CFG_MAX_STEP, 32'd4000);
                    write_reg(CFG_FALLBACK, 32'd0);
                end
                default: ;
            endcase
            i_cfg_valid <= 1'b0;
            send_beat(CMD_RESET, '0, '0, '0, '0, '0);
            send_beat(CMD_MEASURE, '0, rand_pos(2), rand_pos(2), rand_pos(2), '0);
            repeat (102) random_beat(ph == 0 ? 0 : (ph == 1 ? 1 : 2));
            drain();
        end

        $display("covered %0d input beats and %0d result beats over four register settings",
                 beats, results);
        $display("idling varied per phase, with a queue-fill hold-off and a full drain");
        if (errors == 0) begin
            $display("PASS motion_segment_executor");
        end else begin
            $display("FAIL motion_segment_executor");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_datapath.sv
rtl/mse_ctrl.sv
rtl/motion_segment_executor.sv
dv/mse_checker.sv
dv/testbench.sv
